// ----- sv/sic_pkg.sv -----
package sic_pkg;

   localparam int FIELD_W  = 16;
   localparam int VEC_W    = FIELD_W + 1;      // room for the Burgers sum
   localparam int PROD_W   = 2 * VEC_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int DOT_W    = 35;
   localparam int NORM_W   = 34;
   localparam int MAG_W    = 33;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int NPROD_W  = 2 * NORM_W;
   localparam int HALF_W   = NORM_W;
   localparam int THR_W    = 16;
   localparam int THR_SQ_W = 2 * THR_W;
   localparam int PART_W   = THR_SQ_W + HALF_W;
   localparam int CMP_W    = 100;
   localparam int FRAC_SHIFT = 32;

   localparam int NAXIS = 3;
   localparam int NSRC  = 4;
   localparam int NVEC  = 5;
   localparam int NSUM  = 9;
   localparam int NDOT  = 4;
   localparam int NNORM = 5;
   localparam int NPAIR = 4;
   localparam int NTEST = 5;
   localparam int NTHR  = 2;

   localparam int QUEUE_DEPTH_DEF  = 8;
   localparam int RESULT_DEPTH_DEF = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_PERP     = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_PARALLEL = REG_IDX_W'(1);
   localparam logic [THR_W-1:0] PERP_RESET     = 16'd1311;
   localparam logic [THR_W-1:0] PARALLEL_RESET = 16'd64225;

   // vectors: Burgers a/b, plane normals a/b, Burgers sum
   localparam int VEC_BA = 0;
   localparam int VEC_BB = 1;
   localparam int VEC_PA = 2;
   localparam int VEC_PB = 3;
   localparam int VEC_BS = 4;

   // dot products first, squared norms after
   localparam int SUM_L [NSUM] = '{VEC_BA, VEC_PA, VEC_PA, VEC_PB,
                                   VEC_BA, VEC_BB, VEC_PA, VEC_PB, VEC_BS};
   localparam int SUM_R [NSUM] = '{VEC_BB, VEC_PB, VEC_BS, VEC_BS,
                                   VEC_BA, VEC_BB, VEC_PA, VEC_PB, VEC_BS};

   // norm index pairs multiplied together
   localparam int PAIR_L [NPAIR] = '{0, 2, 2, 3};
   localparam int PAIR_R [NPAIR] = '{1, 3, 4, 4};

   localparam int THR_PERP     = 0;
   localparam int THR_PARALLEL = 1;

   localparam int TEST_HIRTH   = 0;
   localparam int TEST_ALIGN   = 1;
   localparam int TEST_COPLANE = 2;
   localparam int TEST_GLIDE_A = 3;
   localparam int TEST_GLIDE_B = 4;

   localparam int TEST_DOT  [NTEST] = '{0, 0, 1, 2, 3};
   localparam int TEST_PAIR [NTEST] = '{0, 0, 1, 2, 3};
   localparam int TEST_THR  [NTEST] = '{THR_PERP, THR_PARALLEL, THR_PARALLEL,
                                        THR_PERP, THR_PERP};

   typedef enum logic [2:0] {
      MODE_NONE     = 3'd0,
      MODE_HIRTH    = 3'd1,
      MODE_COPLANAR = 3'd2,
      MODE_GLISSILE = 3'd3,
      MODE_SESSILE  = 3'd4
   } mode_type;

   typedef logic [NTHR-1:0][THR_SQ_W-1:0] thr_sq_type;

   typedef struct packed {
      logic [NDOT-1:0][DOT_W-1:0]   dot;
      logic [NNORM-1:0][NORM_W-1:0] norm;
   } sums_type;

endpackage

// ----- sv/sic_regs.sv -----
module sic_regs import sic_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output thr_sq_type            thr_sq
);

   logic [THR_W-1:0]     perp_ff, perp_in;
   logic [THR_W-1:0]     parallel_ff, parallel_in;
   thr_sq_type           thr_sq_ff, thr_sq_in;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr     = psel && penable && pwrite && pready;

   always_comb begin
      perp_in     = perp_ff;
      parallel_in = parallel_ff;
      prdata      = '0;
      unique case (idx)
         REG_PERP: begin
            if (wr) perp_in = pwdata[THR_W-1:0];
            prdata = CSR_DATA_W'(perp_ff);
         end
         REG_PARALLEL: begin
            if (wr) parallel_in = pwdata[THR_W-1:0];
            prdata = CSR_DATA_W'(parallel_ff);
         end
         default: begin
         end
      endcase
      thr_sq_in[THR_PERP]     = THR_SQ_W'(perp_ff) * THR_SQ_W'(perp_ff);
      thr_sq_in[THR_PARALLEL] = THR_SQ_W'(parallel_ff) * THR_SQ_W'(parallel_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perp_ff     <= PERP_RESET;
         parallel_ff <= PARALLEL_RESET;
      end else begin
         perp_ff     <= perp_in;
         parallel_ff <= parallel_in;
      end
      thr_sq_ff <= thr_sq_in;
   end

   assign thr_sq = thr_sq_ff;

endmodule

// ----- sv/sic_fifo.sv -----
module sic_fifo import sic_pkg::*; #(
   parameter int WIDTH = $bits(sums_type),
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("sic_fifo: write while full");

endmodule

// ----- sv/sic_front.sv -----
module sic_front import sic_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [NSRC-1:0][NAXIS-1:0][FIELD_W-1:0] src,
   input  logic                                  q_pop,
   output logic                                  q_push,
   output sums_type                              q_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    v0_ff, v1_ff, v2_ff;
   logic                    take;
   logic signed [VEC_W-1:0]  vec_ff  [NVEC][NAXIS];
   logic signed [VEC_W-1:0]  vec_in  [NVEC][NAXIS];
   logic signed [PROD_W-1:0] prod_ff [NSUM][NAXIS];
   logic signed [PROD_W-1:0] prod_in [NSUM][NAXIS];
   logic signed [SUM_W-1:0]  sum_all [NSUM];
   sums_type                sums_ff, sums_in;

   // credit covers every request between the input and the queue read
   assign full = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign take = push && !full;

   always_comb begin
      cnt_in = cnt_ff;
      if (take && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!take && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      for (int a = 0; a < NAXIS; a++) begin
         for (int s = 0; s < NSRC; s++) begin
            vec_in[s][a] = VEC_W'(signed'(src[s][a]));
         end
         vec_in[VEC_BS][a] = VEC_W'(signed'(src[VEC_BA][a]))
                           + VEC_W'(signed'(src[VEC_BB][a]));
      end
   end

   always_comb begin
      for (int k = 0; k < NSUM; k++) begin
         for (int a = 0; a < NAXIS; a++) begin
            prod_in[k][a] = vec_ff[SUM_L[k]][a] * vec_ff[SUM_R[k]][a];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NSUM; k++) begin
         sum_all[k] = SUM_W'(prod_ff[k][0]) + SUM_W'(prod_ff[k][1])
                    + SUM_W'(prod_ff[k][2]);
      end
      for (int k = 0; k < NDOT; k++) begin
         sums_in.dot[k] = sum_all[k][DOT_W-1:0];
      end
      for (int n = 0; n < NNORM; n++) begin
         sums_in.norm[n] = sum_all[NDOT + n][NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         v0_ff  <= take;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
      end
      if (take) vec_ff <= vec_in;
      if (v0_ff) prod_ff <= prod_in;
      if (v1_ff) sums_ff <= sums_in;
   end

   assign q_push = v2_ff;
   assign q_data = sums_ff;

   a_front_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##3 q_push)
      else $error("sic_front: request did not reach the queue");

   a_front_credit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("sic_front: credit count overrun");

endmodule

// ----- sv/sic_back.sv -----
module sic_back import sic_pkg::*; #(
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  thr_sq_type thr_sq,
   input  logic       q_empty,
   input  sums_type   q_data,
   output logic       q_pop,
   output logic       r_push,
   output mode_type   r_mode,
   input  logic       r_pop
);

   localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               v0_ff, v1_ff, v2_ff;
   logic [MAG_W-1:0]   mag_ff  [NDOT];
   logic [MAG_W-1:0]   mag_in  [NDOT];
   logic [NORM_W-1:0]  norm_ff [NNORM];
   logic [SQ_W-1:0]    sq_ff   [NDOT];
   logic [SQ_W-1:0]    sq_in   [NDOT];
   logic [SQ_W-1:0]    sq2_ff  [NDOT];
   logic [NPROD_W-1:0] pair_ff [NPAIR];
   logic [NPROD_W-1:0] pair_in [NPAIR];
   logic [PART_W-1:0]  lo_ff   [NTEST];
   logic [PART_W-1:0]  lo_in   [NTEST];
   logic [PART_W-1:0]  hi_ff   [NTEST];
   logic [PART_W-1:0]  hi_in   [NTEST];
   logic [NTEST-1:0]   below, above;
   logic [DOT_W-1:0]   abs_dot;
   logic [CMP_W-1:0]   lhs, rhs;

   assign q_pop = !q_empty && (cnt_ff != CNT_W'(RESULT_DEPTH));

   always_comb begin
      cnt_in = cnt_ff;
      if (q_pop && !r_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!q_pop && r_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      abs_dot = '0;
      for (int i = 0; i < NDOT; i++) begin
         abs_dot   = q_data.dot[i][DOT_W-1] ? (~q_data.dot[i] + 1'b1) : q_data.dot[i];
         mag_in[i] = abs_dot[MAG_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < NDOT; i++) begin
         sq_in[i] = SQ_W'(mag_ff[i]) * SQ_W'(mag_ff[i]);
      end
      for (int p = 0; p < NPAIR; p++) begin
         pair_in[p] = NPROD_W'(norm_ff[PAIR_L[p]]) * NPROD_W'(norm_ff[PAIR_R[p]]);
      end
   end

   // threshold square times the norm product, in two halves
   always_comb begin
      for (int t = 0; t < NTEST; t++) begin
         lo_in[t] = PART_W'(thr_sq[TEST_THR[t]])
                  * PART_W'(pair_ff[TEST_PAIR[t]][HALF_W-1:0]);
         hi_in[t] = PART_W'(thr_sq[TEST_THR[t]])
                  * PART_W'(pair_ff[TEST_PAIR[t]][NPROD_W-1:HALF_W]);
      end
   end

   always_comb begin
      lhs = '0;
      rhs = '0;
      for (int t = 0; t < NTEST; t++) begin
         rhs      = (CMP_W'(hi_ff[t]) << HALF_W) + CMP_W'(lo_ff[t]);
         lhs      = CMP_W'(sq2_ff[TEST_DOT[t]]) << FRAC_SHIFT;
         below[t] = (lhs < rhs);
         above[t] = (lhs > rhs);
      end
      if (below[TEST_HIRTH]) begin
         r_mode = MODE_HIRTH;
      end else if (above[TEST_ALIGN]) begin
         r_mode = MODE_NONE;
      end else if (above[TEST_COPLANE]) begin
         r_mode = MODE_COPLANAR;
      end else if (below[TEST_GLIDE_A] || below[TEST_GLIDE_B]) begin
         r_mode = MODE_GLISSILE;
      end else begin
         r_mode = MODE_SESSILE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         v0_ff  <= q_pop;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
      end
      if (q_pop) begin
         mag_ff <= mag_in;
         for (int n = 0; n < NNORM; n++) norm_ff[n] <= q_data.norm[n];
      end
      if (v0_ff) begin
         sq_ff   <= sq_in;
         pair_ff <= pair_in;
      end
      if (v1_ff) begin
         sq2_ff <= sq_ff;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
      end
   end

   assign r_push = v2_ff;

   a_back_latency: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> ##3 r_push)
      else $error("sic_back: request did not reach the result queue");

   a_back_one_mode: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> !(below[TEST_HIRTH] && above[TEST_HIRTH]) &&
                !(below[TEST_ALIGN] && above[TEST_ALIGN]))
      else $error("sic_back: compare both below and above");

endmodule

// ----- sv/slip_interaction_classifier_top.sv -----
// Channel   Ports                                   Handshake
// request   req_push, req_full, req_<field> x12     taken when req_push && !req_full
// response  rsp_empty, rsp_pop, rsp_mode            taken when rsp_pop && !rsp_empty
// csr       csr_psel/penable/pwrite/paddr/pwdata    written on psel&penable&pwrite&pready
//
// One request per cycle while req_full is low; each response passes through the
// front (vector, per-axis product and dot/norm sum registers), the middle queue
// and the back (magnitude/norm, square/norm-product and threshold-product registers).
// Reset (synchronous) empties both queues and loads the threshold defaults.
// req_full rises when 8 requests sit between the input and the middle queue read;
// the back stops reading the middle queue while 8 responses are pending.
module slip_interaction_classifier_top import sic_pkg::*; #(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [FIELD_W-1:0] req_burg_a_x,
   input  logic signed [FIELD_W-1:0] req_burg_a_y,
   input  logic signed [FIELD_W-1:0] req_burg_a_z,
   input  logic signed [FIELD_W-1:0] req_plane_a_x,
   input  logic signed [FIELD_W-1:0] req_plane_a_y,
   input  logic signed [FIELD_W-1:0] req_plane_a_z,
   input  logic signed [FIELD_W-1:0] req_burg_b_x,
   input  logic signed [FIELD_W-1:0] req_burg_b_y,
   input  logic signed [FIELD_W-1:0] req_burg_b_z,
   input  logic signed [FIELD_W-1:0] req_plane_b_x,
   input  logic signed [FIELD_W-1:0] req_plane_b_y,
   input  logic signed [FIELD_W-1:0] req_plane_b_z,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [2:0]                rsp_mode,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int MODE_W = $bits(mode_type);

   logic [NSRC-1:0][NAXIS-1:0][FIELD_W-1:0] src;
   thr_sq_type           thr_sq;
   logic                 q_push, q_pop, q_empty;
   sums_type             q_wr_data, q_rd_data;
   logic                 r_push;
   mode_type             r_mode;
   logic [MODE_W-1:0]    r_rd_data;
   logic                 rsp_take;

   assign src[VEC_BA][0] = req_burg_a_x;
   assign src[VEC_BA][1] = req_burg_a_y;
   assign src[VEC_BA][2] = req_burg_a_z;
   assign src[VEC_BB][0] = req_burg_b_x;
   assign src[VEC_BB][1] = req_burg_b_y;
   assign src[VEC_BB][2] = req_burg_b_z;
   assign src[VEC_PA][0] = req_plane_a_x;
   assign src[VEC_PA][1] = req_plane_a_y;
   assign src[VEC_PA][2] = req_plane_a_z;
   assign src[VEC_PB][0] = req_plane_b_x;
   assign src[VEC_PB][1] = req_plane_b_y;
   assign src[VEC_PB][2] = req_plane_b_z;

   assign rsp_take = rsp_pop && !rsp_empty;
   assign rsp_mode = r_rd_data;

   sic_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .thr_sq  (thr_sq)
   );

   sic_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .full   (req_full),
      .src    (src),
      .q_pop  (q_pop),
      .q_push (q_push),
      .q_data (q_wr_data)
   );

   sic_fifo #(.WIDTH($bits(sums_type)), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty),
      .full    ()
   );

   sic_back #(.RESULT_DEPTH(RESULT_DEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .thr_sq  (thr_sq),
      .q_empty (q_empty),
      .q_data  (q_rd_data),
      .q_pop   (q_pop),
      .r_push  (r_push),
      .r_mode  (r_mode),
      .r_pop   (rsp_take)
   );

   sic_fifo #(.WIDTH(MODE_W), .DEPTH(RESULT_DEPTH)) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (r_push),
      .wr_data (r_mode),
      .pop     (rsp_take),
      .rd_data (r_rd_data),
      .empty   (rsp_empty),
      .full    ()
   );

endmodule

// ----- tb/tb_slip_interaction_classifier_top.sv -----
module tb_slip_interaction_classifier_top;
   import sic_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DIR_LIM         = 4;

   typedef logic signed [FIELD_W-1:0] vec_type [NAXIS];
   typedef longint wide_vec_type [NAXIS];
   typedef int dir_type [NAXIS];
   typedef int raw_pair_type [12];

   typedef struct {
      vec_type burg_a;
      vec_type plane_a;
      vec_type burg_b;
      vec_type plane_b;
   } slip_pair_type;

   typedef enum int {
      PICK_NOISE, PICK_CORNER, PICK_TINY, PICK_ZERO, PICK_HIRTH,
      PICK_ALIGNED, PICK_COPLANAR, PICK_GLIDE, PICK_SESSILE
   } pair_kind_type;

   typedef enum int { VALS_FULL, VALS_CORNER, VALS_TINY } vals_type;

   class slip_scoreboard;
      logic [THR_W-1:0] perp_thr;
      logic [THR_W-1:0] par_thr;
      mode_type pending_modes [$];
      int errors;
      int checked;
      int mode_seen [5];

      function new();
         perp_thr = PERP_RESET;
         par_thr  = PARALLEL_RESET;
         errors   = 0;
         checked  = 0;
         foreach (mode_seen[i]) mode_seen[i] = 0;
      endfunction

      function longint dot3(wide_vec_type u, wide_vec_type v);
         return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      endfunction

      // sign of dot^2 * 2^32 - t^2 * |u|^2 * |v|^2
      function int cos_order(longint d, longint nu, longint nv, logic [THR_W-1:0] t);
         logic [127:0] mag;
         logic [127:0] lhs;
         logic [127:0] rhs;
         mag = (d < 0) ? 128'(-d) : 128'(d);
         lhs = (mag * mag) << FRAC_SHIFT;
         rhs = 128'(t) * 128'(t) * 128'(nu) * 128'(nv);
         if (lhs < rhs) return -1;
         if (lhs > rhs) return 1;
         return 0;
      endfunction

      function mode_type classify(slip_pair_type p);
         wide_vec_type ba, bb, pa, pb, bs;
         longint nba, nbb, npa, npb, nbs, d;
         for (int i = 0; i < NAXIS; i++) begin
            ba[i] = p.burg_a[i];
            bb[i] = p.burg_b[i];
            pa[i] = p.plane_a[i];
            pb[i] = p.plane_b[i];
            bs[i] = ba[i] + bb[i];
         end
         nba = dot3(ba, ba);
         nbb = dot3(bb, bb);
         npa = dot3(pa, pa);
         npb = dot3(pb, pb);
         nbs = dot3(bs, bs);
         d   = dot3(ba, bb);
         if (cos_order(d, nba, nbb, perp_thr) < 0) return MODE_HIRTH;
         if (cos_order(d, nba, nbb, par_thr) > 0) return MODE_NONE;
         if (cos_order(dot3(pa, pb), npa, npb, par_thr) > 0) return MODE_COPLANAR;
         if (cos_order(dot3(pa, bs), npa, nbs, perp_thr) < 0 ||
             cos_order(dot3(pb, bs), npb, nbs, perp_thr) < 0) return MODE_GLISSILE;
         return MODE_SESSILE;
      endfunction

      function void note_request(slip_pair_type p);
         pending_modes = {pending_modes, classify(p)};
      endfunction

      function void check_response(logic [2:0] got);
         mode_type want;
         if (pending_modes.size() == 0) begin
            $display("%0t: response mode %0d with no request outstanding", $time, got);
            errors++;
            return;
         end
         want = pending_modes.pop_front();
         checked++;
         mode_seen[int'(want)]++;
         if (got !== 3'(want)) begin
            $display("%0t: mode mismatch, expected %0d (%s) got %0d",
                     $time, want, want.name(), got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [FIELD_W-1:0] req_burg_a_x = '0;
   logic signed [FIELD_W-1:0] req_burg_a_y = '0;
   logic signed [FIELD_W-1:0] req_burg_a_z = '0;
   logic signed [FIELD_W-1:0] req_plane_a_x = '0;
   logic signed [FIELD_W-1:0] req_plane_a_y = '0;
   logic signed [FIELD_W-1:0] req_plane_a_z = '0;
   logic signed [FIELD_W-1:0] req_burg_b_x = '0;
   logic signed [FIELD_W-1:0] req_burg_b_y = '0;
   logic signed [FIELD_W-1:0] req_burg_b_z = '0;
   logic signed [FIELD_W-1:0] req_plane_b_x = '0;
   logic signed [FIELD_W-1:0] req_plane_b_y = '0;
   logic signed [FIELD_W-1:0] req_plane_b_z = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [2:0] rsp_mode;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   slip_scoreboard sb;
   bit calm = 1'b0;
   bit hold_off_pending = 1'b0;
   int sent = 0;
   int settings = 1;

   slip_interaction_classifier_top DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_burg_a_x(req_burg_a_x), .req_burg_a_y(req_burg_a_y),
      .req_burg_a_z(req_burg_a_z),
      .req_plane_a_x(req_plane_a_x), .req_plane_a_y(req_plane_a_y),
      .req_plane_a_z(req_plane_a_z),
      .req_burg_b_x(req_burg_b_x), .req_burg_b_y(req_burg_b_y),
      .req_burg_b_z(req_burg_b_z),
      .req_plane_b_x(req_plane_b_x), .req_plane_b_y(req_plane_b_y),
      .req_plane_b_z(req_plane_b_z),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_mode(rsp_mode),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   // mostly short, now and then long
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic dir_type rand_dir(int lim);
      dir_type d;
      foreach (d[i]) d[i] = int'($urandom_range(0, 2 * lim)) - lim;
      return d;
   endfunction

   function automatic dir_type cross_dir(dir_type a, dir_type b);
      dir_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   function automatic int dir_peak(dir_type d);
      int m;
      m = 0;
      foreach (d[i]) if ((d[i] < 0 ? -d[i] : d[i]) > m) m = (d[i] < 0 ? -d[i] : d[i]);
      return m;
   endfunction

   function automatic int rand_scale(int peak);
      int k;
      k = (peak == 0) ? 1 : int'($urandom_range(1, 32767 / peak));
      return $urandom_range(0, 1) ? k : -k;
   endfunction

   // scale a lattice direction into Q8.8, optionally with a few LSBs of noise
   function automatic vec_type place(dir_type d, bit jitter);
      vec_type v;
      int k;
      k = rand_scale(dir_peak(d));
      foreach (v[i]) begin
         v[i] = FIELD_W'(clamp16(d[i] * k +
                 (jitter ? int'($urandom_range(0, 6)) - 3 : 0)));
      end
      return v;
   endfunction

   function automatic vec_type raw_vec(vals_type how);
      vec_type v;
      int sel;
      foreach (v[i]) begin
         sel = $urandom_range(0, 6);
         case (how)
            VALS_FULL: v[i] = FIELD_W'($urandom);
            VALS_TINY: v[i] = FIELD_W'(int'($urandom_range(0, 4)) - 2);
            default: begin
               case (sel)
                  0: v[i] = -16'sd32768;
                  1: v[i] = -16'sd32767;
                  2: v[i] = -16'sd1;
                  3: v[i] = 16'sd0;
                  4: v[i] = 16'sd1;
                  5: v[i] = 16'sd32767;
                  default: v[i] = FIELD_W'($urandom);
               endcase
            end
         endcase
      end
      return v;
   endfunction

   function automatic slip_pair_type random_pair();
      pair_kind_type kind;
      dir_type da, db, dp, dq, w, ds, dn;
      slip_pair_type p;
      bit jit;
      int k;
      vec_type zero_v;
      kind = pair_kind_type'($urandom_range(0, 8));
      jit  = ($urandom_range(0, 3) == 0);
      da = rand_dir(DIR_LIM);
      db = rand_dir(DIR_LIM);
      dp = rand_dir(DIR_LIM);
      dq = rand_dir(DIR_LIM);
      w  = rand_dir(DIR_LIM);
      foreach (zero_v[i]) zero_v[i] = '0;
      p.burg_a  = place(da, jit);
      p.burg_b  = place(db, jit);
      p.plane_a = place(dp, jit);
      p.plane_b = place(dq, jit);
      case (kind)
         PICK_NOISE, PICK_CORNER, PICK_TINY: begin
            p.burg_a  = raw_vec(kind == PICK_NOISE ? VALS_FULL :
                                kind == PICK_TINY ? VALS_TINY : VALS_CORNER);
            p.burg_b  = raw_vec(kind == PICK_NOISE ? VALS_FULL :
                                kind == PICK_TINY ? VALS_TINY : VALS_CORNER);
            p.plane_a = raw_vec(kind == PICK_NOISE ? VALS_FULL :
                                kind == PICK_TINY ? VALS_TINY : VALS_CORNER);
            p.plane_b = raw_vec(kind == PICK_NOISE ? VALS_FULL :
                                kind == PICK_TINY ? VALS_TINY : VALS_CORNER);
         end
         PICK_ZERO: begin
            case ($urandom_range(0, 3))
               0: p.burg_a = zero_v;
               1: p.burg_b = zero_v;
               2: p.plane_a = zero_v;
               default: p.plane_b = zero_v;
            endcase
         end
         PICK_HIRTH: p.burg_b = place(cross_dir(da, w), jit);
         PICK_ALIGNED: p.burg_b = place(da, jit);
         PICK_COPLANAR: p.plane_b = place(dp, jit);
         PICK_GLIDE: begin
            // Burgers sum made to lie in one of the planes
            if ($urandom_range(0, 1)) begin
               dn = dp;
            end else begin
               dn = dq;
            end
            ds = cross_dir(dn, w);
            foreach (db[i]) db[i] = ds[i] - da[i];
            k = rand_scale(dir_peak(da) > dir_peak(db) ? dir_peak(da) : dir_peak(db));
            foreach (da[i]) begin
               p.burg_a[i] = FIELD_W'(da[i] * k);
               p.burg_b[i] = FIELD_W'(db[i] * k);
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic slip_pair_type from_raw(raw_pair_type r);
      slip_pair_type p;
      for (int i = 0; i < NAXIS; i++) begin
         p.burg_a[i]  = FIELD_W'(r[i]);
         p.plane_a[i] = FIELD_W'(r[3 + i]);
         p.burg_b[i]  = FIELD_W'(r[6 + i]);
         p.plane_b[i] = FIELD_W'(r[9 + i]);
      end
      return p;
   endfunction

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_pair(slip_pair_type p);
      req_burg_a_x  <= p.burg_a[0];
      req_burg_a_y  <= p.burg_a[1];
      req_burg_a_z  <= p.burg_a[2];
      req_plane_a_x <= p.plane_a[0];
      req_plane_a_y <= p.plane_a[1];
      req_plane_a_z <= p.plane_a[2];
      req_burg_b_x  <= p.burg_b[0];
      req_burg_b_y  <= p.burg_b[1];
      req_burg_b_z  <= p.burg_b[2];
      req_plane_b_x <= p.plane_b[0];
      req_plane_b_y <= p.plane_b[1];
      req_plane_b_z <= p.plane_b[2];
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_request(p);
      sent++;
   endtask

   task automatic sender_gap();
      int n;
      if (calm || $urandom_range(0, 99) >= 35) return;
      n = idle_len();
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending_modes.size() != 0) @(posedge clock);
   endtask

   // both thresholds, back to back on the bus
   task automatic write_thresholds(logic [31:0] perp_val, logic [31:0] par_val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({REG_PERP, 2'b00});
      csr_pwdata  <= perp_val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.perp_thr = perp_val[THR_W-1:0];
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({REG_PARALLEL, 2'b00});
      csr_pwdata  <= par_val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.par_thr = par_val[THR_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings++;
   endtask

   task automatic run_random(int n);
      repeat (n) begin
         if (sent % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         send_pair(random_pair());
         sender_gap();
      end
      calm = 1'b0;
   endtask

   task automatic run_directed();
      raw_pair_type cases [20];
      cases = '{
         '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{-32768, -32768, -32768, -32768, -32768, -32768,
           -32768, -32768, -32768, -32768, -32768, -32768},
         '{32767, 32767, 32767, 32767, 32767, 32767,
           32767, 32767, 32767, 32767, 32767, 32767},
         '{32767, 0, 0, 0, 0, 32767, 0, -32768, 0, -32768, 0, 0},
         '{-32768, -32768, -32768, 256, 0, 0, 32767, 32767, 32767, 0, 256, 0},
         '{256, 0, 0, 0, 0, 256, 256, 256, 0, 0, 0, -256},
         '{256, 0, 0, 0, 0, 256, 256, 256, 0, 0, 256, 256},
         '{256, 0, 0, 0, 256, 256, 256, 256, 0, 0, 0, 256},
         '{256, 0, 0, 256, 256, 256, 256, 256, 0, 0, 256, 256},
         '{0, 0, 0, 0, 0, 256, 256, 256, 0, 0, 256, 256},
         '{256, 256, 0, 0, 0, 256, 0, 0, 0, 0, 256, 256},
         '{256, 0, 0, 0, 0, 0, 256, 256, 0, 0, 256, 256},
         '{256, 512, -256, 256, 0, 0, -256, -512, 256, 0, 256, 0},
         '{21845, -21846, 21845, 21845, 21845, -21846,
           -21846, 21845, -21846, -21846, -21846, 21845},
         '{1, 0, 0, -1, -1, -1, 0, 0, 1, 1, -1, 0},
         '{32767, 0, 0, 0, 0, 256, 600, 32767, 0, 256, 256, 256},
         '{32767, 0, 0, 0, 0, 256, 700, 32767, 0, 256, 256, 256},
         '{32767, 0, 0, 0, 0, 256, 32767, 6000, 0, 256, 0, 0},
         '{32767, 0, 0, 0, 0, 256, 32767, 7000, 0, 256, 0, 0},
         '{-32768, 32767, 0, 32767, -32768, 1, -32768, -32768, 32767, -1, 0, -32768}
      };
      foreach (cases[i]) begin
         send_pair(from_raw(cases[i]));
         sender_gap();
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) sb.check_response(rsp_mode);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 99) < 25) begin
            rsp_pop <= 1'b0;
            stall_left = idle_len() - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(280);
      drain();

      // thresholds at the extremes, junk in the upper half
      write_thresholds({16'hFFFF, 16'h0000}, {16'h0000, 16'hFFFF});
      run_random(150);
      drain();
      write_thresholds({16'h0000, 16'hFFFF}, {16'hABCD, 16'h0000});
      run_random(150);
      drain();

      // defaults back; receiver holds off while requests keep coming
      write_thresholds({16'($urandom), PERP_RESET}, {16'($urandom), PARALLEL_RESET});
      calm = 1'b1;
      hold_off_pending = 1'b1;
      repeat (200) send_pair(random_pair());
      drain();
      calm = 1'b0;

      repeat (2) begin
         write_thresholds($urandom, $urandom);
         run_random(150);
         drain();
         write_thresholds({16'($urandom), 16'($urandom_range(0, 8000))},
                          {16'($urandom), 16'($urandom_range(50000, 65535))});
         run_random(150);
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Checked %0d responses: none %0d, Hirth %0d, coplanar %0d",
               sb.checked, sb.mode_seen[MODE_NONE], sb.mode_seen[MODE_HIRTH],
               sb.mode_seen[MODE_COPLANAR]);
      $display("  glissile %0d, sessile %0d; %0d threshold settings, one %0d-cycle hold-off",
               sb.mode_seen[MODE_GLISSILE], sb.mode_seen[MODE_SESSILE],
               settings, HOLD_OFF_CYCLES);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/sic_pkg.sv
sv/sic_regs.sv
sv/sic_fifo.sv
sv/sic_front.sv
sv/sic_back.sv
sv/slip_interaction_classifier_top.sv
tb/tb_slip_interaction_classifier_top.sv
